@@ src/metu_pkg.sv @@
// ----------------------------------------------------------------------------
// metu_pkg: shared types and constants of the multi-channel event timer
// Function codes, channel kinds, result kinds and the record kept per channel.
// ----------------------------------------------------------------------------
`default_nettype none

package metu_pkg;

  localparam int CHANNELS_DEF = 10;
  localparam int CH_W         = 4;

  typedef enum logic [2:0] {
    FUNC_TICK  = 3'd0,
    FUNC_EVERY = 3'd1,
    FUNC_OSC   = 3'd2,
    FUNC_PULSE = 3'd3,
    FUNC_STOP  = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    KIND_FREE  = 2'd0,
    KIND_EVERY = 2'd1,
    KIND_OSC   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    EV_ASSIGNED = 2'd0,
    EV_NO_FREE  = 2'd1,
    EV_CALLBACK = 2'd2,
    EV_TOGGLE   = 2'd3
  } ev_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_FLUSH
  } st_t;

  typedef struct packed {
    logic [31:0]        period;
    logic signed [17:0] limit;
    logic [7:0]         pin;
    logic               level;
    logic [31:0]        last_time;
    logic [15:0]        count;
  } chan_rec_t;

  typedef struct packed {
    logic            en;
    logic [CH_W-1:0] idx;
    kind_t           kind;
  } kind_wr_t;

  typedef struct packed {
    logic            en;
    logic [CH_W-1:0] idx;
    chan_rec_t       rec;
  } rec_wr_t;

  typedef struct packed {
    logic            free_ok;
    logic [CH_W-1:0] free_idx;
    kind_t           rd_kind;
  } tbl_stat_t;

  typedef struct packed {
    ev_kind_t        kind;
    logic [CH_W-1:0] ch;
    logic            pw;
    logic [7:0]      pn;
    logic            pl;
  } res_t;

endpackage

`default_nettype wire

@@ src/multi_channel_event_timer_unit.sv @@
// ----------------------------------------------------------------------------
// multi_channel_event_timer_unit: multi-channel software event timer
// Stop and unused codes give no result. A set-up result sits in the output
// register in the cycle after the transfer, and the next transfer waits for it
// to leave. A tick walks the channels, through the read state for a free and the
// read and evaluate states for an active channel with the shared elapsed-time
// compare, then flushes the final result; output stalls can hold the walk.
// Reset frees all channels and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_event_timer_unit #(
  parameter int CHANNELS = metu_pkg::CHANNELS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_func,
  input  wire logic [31:0] in_now,
  input  wire logic [31:0] in_period,
  input  wire logic [15:0] in_repeat_count,
  input  wire logic [7:0]  in_pin,
  input  wire logic        in_level,
  input  wire logic [3:0]  in_channel,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_event_kind,
  output logic [3:0]       out_channel_id,
  output logic             out_pin_write,
  output logic [7:0]       out_pin_number,
  output logic             out_pin_level,
  output logic             out_last
);
  import metu_pkg::*;

  localparam int CIW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  st_t            state_r, state_nxt;
  logic [CIW-1:0] idx_r, idx_nxt;
  logic [31:0]    now_r, now_nxt;
  res_t           pend_r, pend_nxt;
  logic           pend_v_r, pend_v_nxt;
  res_t           out_r, out_nxt;
  logic           out_last_r, out_last_nxt;
  logic           out_valid_r, out_valid_nxt;

  kind_wr_t  kind_wr;
  rec_wr_t   rec_wr;
  chan_rec_t rd_rec;
  tbl_stat_t stat;

  logic        in_xfer;
  logic        out_free;
  logic        last_idx;
  logic [31:0] elapsed;
  logic        fire;
  logic [15:0] count_new;
  logic        retire;
  func_t       func;

  metu_table #(
    .CHANNELS (CHANNELS),
    .CIW      (CIW)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .kind_wr (kind_wr),
    .rec_wr  (rec_wr),
    .rd_idx  (idx_r),
    .rd_rec  (rd_rec),
    .stat    (stat)
  );

  assign func     = func_t'(in_func);
  assign in_stall = (state_r != ST_IDLE) || out_valid_r;
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign last_idx = (idx_r == CIW'(CHANNELS - 1));

  assign elapsed   = now_r - rd_rec.last_time;
  assign fire      = (elapsed >= rd_rec.period);
  assign count_new = !fire ? rd_rec.count :
                     (rd_rec.count == 16'hFFFF) ? rd_rec.count : rd_rec.count + 16'd1;
  assign retire    = !rd_rec.limit[17] && ($signed({2'b00, count_new}) >= rd_rec.limit);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    now_nxt       = now_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    out_nxt       = out_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && out_stall;
    kind_wr       = '0;
    rec_wr        = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (func)
            FUNC_EVERY, FUNC_OSC, FUNC_PULSE: begin
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b1;
              if (stat.free_ok) begin
                rec_wr.en            = 1'b1;
                rec_wr.idx           = stat.free_idx;
                rec_wr.rec.period    = in_period;
                rec_wr.rec.pin       = in_pin;
                rec_wr.rec.level     = in_level;
                rec_wr.rec.last_time = in_now;
                rec_wr.rec.count     = '0;
                kind_wr.en           = 1'b1;
                kind_wr.idx          = stat.free_idx;
                out_nxt.kind         = EV_ASSIGNED;
                out_nxt.ch           = stat.free_idx;
                if (func == FUNC_EVERY) begin
                  rec_wr.rec.limit = {{2{in_repeat_count[15]}}, in_repeat_count};
                  kind_wr.kind     = KIND_EVERY;
                  out_nxt.pw       = 1'b0;
                  out_nxt.pn       = '0;
                  out_nxt.pl       = 1'b0;
                end else begin
                  rec_wr.rec.limit = (func == FUNC_OSC) ?
                                     {in_repeat_count[15], in_repeat_count, 1'b0} : 18'sd1;
                  kind_wr.kind     = KIND_OSC;
                  out_nxt.pw       = 1'b1;
                  out_nxt.pn       = in_pin;
                  out_nxt.pl       = in_level;
                end
              end else begin
                out_nxt = '{kind: EV_NO_FREE, ch: '0, pw: 1'b0, pn: '0, pl: 1'b0};
              end
            end
            FUNC_STOP: begin
              if ({1'b0, in_channel} < 5'(CHANNELS)) begin
                kind_wr.en   = 1'b1;
                kind_wr.idx  = in_channel;
                kind_wr.kind = KIND_FREE;
              end
            end
            FUNC_TICK: begin
              now_nxt   = in_now;
              idx_nxt   = '0;
              state_nxt = ST_READ;
            end
            default: begin
            end
          endcase
        end
      end

      ST_READ: begin
        if (stat.rd_kind == KIND_FREE) begin
          if (last_idx) begin
            state_nxt = ST_FLUSH;
          end else begin
            idx_nxt = idx_r + CIW'(1);
          end
        end else begin
          state_nxt = ST_EVAL;
        end
      end

      ST_EVAL: begin
        if (!(fire && pend_v_r && !out_free)) begin
          if (fire) begin
            rec_wr.en            = 1'b1;
            rec_wr.idx           = CH_W'(idx_r);
            rec_wr.rec           = rd_rec;
            rec_wr.rec.last_time = now_r;
            rec_wr.rec.count     = count_new;
            if (pend_v_r) begin
              out_nxt       = pend_r;
              out_last_nxt  = 1'b0;
              out_valid_nxt = 1'b1;
            end
            pend_v_nxt = 1'b1;
            pend_nxt.ch = CH_W'(idx_r);
            if (stat.rd_kind == KIND_EVERY) begin
              pend_nxt.kind = EV_CALLBACK;
              pend_nxt.pw   = 1'b0;
              pend_nxt.pn   = '0;
              pend_nxt.pl   = 1'b0;
            end else begin
              rec_wr.rec.level = !rd_rec.level;
              pend_nxt.kind    = EV_TOGGLE;
              pend_nxt.pw      = 1'b1;
              pend_nxt.pn      = rd_rec.pin;
              pend_nxt.pl      = !rd_rec.level;
            end
          end
          if (retire) begin
            kind_wr.en   = 1'b1;
            kind_wr.idx  = CH_W'(idx_r);
            kind_wr.kind = KIND_FREE;
          end
          if (last_idx) begin
            state_nxt = ST_FLUSH;
          end else begin
            idx_nxt   = idx_r + CIW'(1);
            state_nxt = ST_READ;
          end
        end
      end

      ST_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_nxt       = pend_r;
          out_last_nxt  = 1'b1;
          out_valid_nxt = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    now_r      <= now_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_event_kind = out_r.kind;
  assign out_channel_id = out_r.ch;
  assign out_pin_write  = out_r.pw;
  assign out_pin_number = out_r.pn;
  assign out_pin_level  = out_r.pl;
  assign out_last       = out_last_r;

endmodule

`default_nettype wire

@@ src/metu_table.sv @@
// ----------------------------------------------------------------------------
// metu_table: channel table of the event timer
// Channel kinds in reset flip-flops with a lowest-free search, and the
// per-channel records in a memory with a write port and a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module metu_table #(
  parameter int CHANNELS = metu_pkg::CHANNELS_DEF,
  parameter int CIW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire metu_pkg::kind_wr_t  kind_wr,
  input  wire metu_pkg::rec_wr_t   rec_wr,
  input  wire logic [CIW-1:0]      rd_idx,
  output metu_pkg::chan_rec_t      rd_rec,
  output metu_pkg::tbl_stat_t      stat
);
  import metu_pkg::*;

  kind_t     kind_r [CHANNELS];
  chan_rec_t mem    [CHANNELS];
  chan_rec_t rd_rec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        kind_r[i] <= KIND_FREE;
      end
    end else if (kind_wr.en) begin
      kind_r[kind_wr.idx[CIW-1:0]] <= kind_wr.kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_wr.en) begin
      mem[rec_wr.idx[CIW-1:0]] <= rec_wr.rec;
    end
    rd_rec_r <= mem[rd_idx];
  end

  assign rd_rec = rd_rec_r;

  always_comb begin
    stat.free_ok  = 1'b0;
    stat.free_idx = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (kind_r[i] == KIND_FREE) begin
        stat.free_ok  = 1'b1;
        stat.free_idx = CH_W'(i);
      end
    end
    stat.rd_kind = kind_r[rd_idx];
  end

endmodule

`default_nettype wire

@@ test/multi_channel_event_timer_unit_test.sv @@
// ----------------------------------------------------------------------------
// multi_channel_event_timer_unit_test: self-checking bench for the event timer
// Drives set-up, tick, stop and unused items through the input channel with
// random idling, predicts every assignment, refusal, callback and pin toggle
// from a private copy of the channel table, and checks each result transfer
// field by field. It also holds the receiver off long enough to back the
// block up.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_event_timer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import metu_pkg::*;

  localparam int CHANNELS    = CHANNELS_DEF;
  localparam int HOLD_CYCLES = 300;
  localparam int LIMIT       = 300000;
  localparam int RANDOM_ITEMS = 160;
  localparam int CALM_TAIL   = 30;

  typedef struct packed {
    logic [2:0]         func;
    logic [31:0]        now;
    logic [31:0]        period;
    logic signed [15:0] repeat_count;
    logic [7:0]         pin;
    logic               level;
    logic [3:0]         chan;
  } stim_t;

  typedef struct packed {
    ev_kind_t   kind;
    logic [3:0] ch;
    logic       pw;
    logic [7:0] pn;
    logic       pl;
    logic       last;
  } event_rec_t;

  class timer_scoreboard;
    kind_t              slot_kind[CHANNELS];
    logic [31:0]        slot_period[CHANNELS];
    logic signed [17:0] slot_limit[CHANNELS];
    logic [7:0]         slot_pin[CHANNELS];
    logic               slot_level[CHANNELS];
    logic [31:0]        slot_stamp[CHANNELS];
    logic [15:0]        slot_fires[CHANNELS];
    event_rec_t         awaited_events[$];
    int                 errors;
    int                 transfers_in;
    int                 seen_kind[4];

    function new();
      foreach (slot_kind[i]) slot_kind[i] = KIND_FREE;
    endfunction

    function void note_transfer(stim_t s);
      event_rec_t made[$];
      event_rec_t r;
      logic signed [17:0] lim;
      int slot;
      slot = -1;
      transfers_in++;
      r = '0;
      case (s.func)
        FUNC_EVERY, FUNC_OSC, FUNC_PULSE: begin
          for (int i = CHANNELS - 1; i >= 0; i--)
            if (slot_kind[i] == KIND_FREE) slot = i;
          if (slot < 0) begin
            r.kind = EV_NO_FREE;
          end else begin
            slot_period[slot] = s.period;
            slot_stamp[slot]  = s.now;
            slot_fires[slot]  = '0;
            lim = s.repeat_count;
            r.kind = EV_ASSIGNED;
            r.ch   = slot[3:0];
            if (s.func == FUNC_EVERY) begin
              slot_kind[slot]  = KIND_EVERY;
              slot_limit[slot] = lim;
            end else begin
              slot_kind[slot]  = KIND_OSC;
              slot_pin[slot]   = s.pin;
              slot_level[slot] = s.level;
              slot_limit[slot] = (s.func == FUNC_OSC) ? (lim <<< 1) : 18'sd1;
              r.pw = 1'b1;
              r.pn = s.pin;
              r.pl = s.level;
            end
          end
          made.push_back(r);
        end
        FUNC_STOP: begin
          if (s.chan < CHANNELS) slot_kind[s.chan] = KIND_FREE;
        end
        FUNC_TICK: begin
          for (int i = 0; i < CHANNELS; i++) begin
            if (slot_kind[i] == KIND_FREE) continue;
            if (32'(s.now - slot_stamp[i]) >= slot_period[i]) begin
              r = '0;
              r.ch = i[3:0];
              if (slot_kind[i] == KIND_EVERY) begin
                r.kind = EV_CALLBACK;
              end else begin
                slot_level[i] = ~slot_level[i];
                r.kind = EV_TOGGLE;
                r.pw   = 1'b1;
                r.pn   = slot_pin[i];
                r.pl   = slot_level[i];
              end
              made.push_back(r);
              slot_stamp[i] = s.now;
              if (slot_fires[i] != 16'hFFFF) slot_fires[i]++;
            end
            if (slot_limit[i] >= 0 && signed'({2'b00, slot_fires[i]}) >= slot_limit[i])
              slot_kind[i] = KIND_FREE;
          end
        end
        default: ;
      endcase
      if (made.size() > 0) made[made.size() - 1].last = 1'b1;
      foreach (made[i]) awaited_events.push_back(made[i]);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_event(event_rec_t got);
      event_rec_t want;
      if (awaited_events.size() == 0) begin
        $error("unexpected result transfer: event_kind %0d channel_id %0d",
               got.kind, got.ch);
        errors++;
        return;
      end
      want = awaited_events.pop_front();
      seen_kind[want.kind]++;
      compare_field("event_kind", want.kind, got.kind);
      compare_field("channel_id", want.ch, got.ch);
      compare_field("pin_write", want.pw, got.pw);
      compare_field("pin_number", want.pn, got.pn);
      compare_field("pin_level", want.pl, got.pl);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_func = '0;
  logic [31:0] in_now = '0;
  logic [31:0] in_period = '0;
  logic [15:0] in_repeat_count = '0;
  logic [7:0]  in_pin = '0;
  logic        in_level = 1'b0;
  logic [3:0]  in_channel = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_event_kind;
  logic [3:0]  out_channel_id;
  logic        out_pin_write;
  logic [7:0]  out_pin_number;
  logic        out_pin_level;
  logic        out_last;

  timer_scoreboard sb = new();
  bit          idling = 1'b1;
  bit          hold_req = 1'b0;
  logic [31:0] ms_now;
  int          cycle_count = 0;

  multi_channel_event_timer_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_now          (in_now),
    .in_period       (in_period),
    .in_repeat_count (in_repeat_count),
    .in_pin          (in_pin),
    .in_level        (in_level),
    .in_channel      (in_channel),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_kind  (out_event_kind),
    .out_channel_id  (out_channel_id),
    .out_pin_write   (out_pin_write),
    .out_pin_number  (out_pin_number),
    .out_pin_level   (out_pin_level),
    .out_last        (out_last)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("multi_channel_event_timer_unit_test: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    stim_t      taken;
    event_rec_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        taken = {in_func, in_now, in_period, in_repeat_count, in_pin, in_level,
                 in_channel};
        sb.note_transfer(taken);
      end
      if (out_valid && !out_stall) begin
        got = {ev_kind_t'(out_event_kind), out_channel_id, out_pin_write,
               out_pin_number, out_pin_level, out_last};
        sb.check_event(got);
      end
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (idling && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic stim_t compose(logic [2:0] func, logic [31:0] now,
                                    logic [31:0] period, logic [15:0] rc,
                                    logic [7:0] pin, logic level, logic [3:0] chan);
    stim_t s;
    s = {func, now, period, rc, pin, level, chan};
    return s;
  endfunction

  task automatic send(stim_t s);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_func         <= s.func;
    in_now          <= s.now;
    in_period       <= s.period;
    in_repeat_count <= s.repeat_count;
    in_pin          <= s.pin;
    in_level        <= s.level;
    in_channel      <= s.chan;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic stim_t random_item();
    stim_t s;
    int pick;
    pick = $urandom_range(0, 99);
    s.func = FUNC_TICK;
    s.period = $urandom_range(0, 40);
    s.repeat_count = 16'($urandom_range(0, 6));
    s.repeat_count = s.repeat_count - 16'sd1;
    s.pin = 8'($urandom);
    s.level = 1'($urandom);
    s.chan = 4'($urandom_range(0, CHANNELS - 1));
    if ($urandom_range(0, 7) == 0) begin
      s.period = $urandom;
      s.repeat_count = 16'($urandom);
    end
    if (pick < 30) begin
      s.func = 3'($urandom_range(FUNC_EVERY, FUNC_PULSE));
    end else if (pick < 45) begin
      s.func = FUNC_STOP;
      if ($urandom_range(0, 4) == 0) s.chan = 4'($urandom_range(0, 15));
    end else if (pick < 95) begin
      ms_now = ms_now + $urandom_range(0, 30);
    end else begin
      s.func = 3'($urandom_range(0, 7));
      s.chan = 4'($urandom_range(0, 15));
    end
    s.now = ms_now;
    if (pick >= 95 && $urandom_range(0, 1) == 0) s.now = $urandom;
    return s;
  endfunction

  initial begin
    stim_t s;
    int counted;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(compose(FUNC_TICK, 32'd0, 32'd0, 16'd0, 8'd0, 1'b0, 4'd0));
    send(compose(FUNC_EVERY, 32'd0, 32'd100, 16'd0, 8'd0, 1'b0, 4'd0));
    send(compose(FUNC_TICK, 32'd0, 32'd0, 16'd0, 8'd0, 1'b0, 4'd0));
    send(compose(FUNC_OSC, 32'd5, 32'hFFFF_FFFF, 16'h7FFF, 8'hFF, 1'b1, 4'd0));
    send(compose(FUNC_PULSE, 32'd10, 32'd0, 16'd0, 8'h00, 1'b0, 4'd0));
    send(compose(FUNC_EVERY, 32'hFFFF_FFF0, 32'h20, 16'hFFFF, 8'd0, 1'b0, 4'd0));
    send(compose(FUNC_OSC, 32'd20, 32'd3, 16'd1, 8'hA5, 1'b0, 4'd0));
    send(compose(FUNC_EVERY, 32'd20, 32'd0, 16'h8000, 8'd0, 1'b0, 4'd0));
    send(compose(FUNC_TICK, 32'h10, 32'd0, 16'd0, 8'd0, 1'b0, 4'd0));
    send(compose(FUNC_TICK, 32'h30, 32'd0, 16'd0, 8'd0, 1'b0, 4'd0));
    send(compose(FUNC_TICK, 32'd4, 32'd0, 16'd0, 8'd0, 1'b0, 4'd0));
    send(compose(FUNC_STOP, 32'd4, 32'd0, 16'd0, 8'd0, 1'b0, 4'd15));
    send(compose(FUNC_STOP, 32'd4, 32'd0, 16'd0, 8'd0, 1'b0, 4'd10));
    send(compose(FUNC_STOP, 32'd4, 32'd0, 16'd0, 8'd0, 1'b0, 4'd4));
    for (int f = FUNC_STOP + 1; f < 8; f++)
      send(compose(f[2:0], $urandom, $urandom, 16'($urandom), 8'($urandom), 1'b1, 4'd0));
    for (int k = 0; k < CHANNELS - 1; k++)
      send(compose(3'($urandom_range(FUNC_EVERY, FUNC_PULSE)), 32'd8, 32'd50, 16'd3,
                   8'($urandom), 1'($urandom), 4'd0));

    // back up the block behind a stalled receiver
    for (int k = 0; k < CHANNELS; k++)
      send(compose(FUNC_STOP, 32'd0, 32'd0, 16'd0, 8'd0, 1'b0, k[3:0]));
    for (int k = 0; k < CHANNELS; k++)
      send(compose((k % 2) ? FUNC_OSC : FUNC_EVERY, 32'd100, 32'd0, 16'hFFFF,
                   k[7:0], 1'b0, 4'd0));
    hold_req = 1'b1;
    for (int k = 0; k < 6; k++)
      send(compose(FUNC_TICK, 32'd101 + k, 32'd0, 16'd0, 8'd0, 1'b0, 4'd0));
    for (int k = 0; k < CHANNELS; k++)
      send(compose(FUNC_STOP, 32'd0, 32'd0, 16'd0, 8'd0, 1'b0, k[3:0]));

    ms_now = 32'hFFFF_FC00;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (counted % 40 == 0) idling = ($urandom_range(0, 3) != 0);
      if (counted >= RANDOM_ITEMS - CALM_TAIL) idling = 1'b0;
      s = random_item();
      send(s);
      if (s.func < FUNC_STOP || (s.func == FUNC_STOP && s.chan < CHANNELS))
        counted++;
    end
    in_valid <= 1'b0;

    while (sb.awaited_events.size() != 0) @(posedge clk);
    repeat (2 * CHANNELS + 8) @(posedge clk);

    $display("summary: %0d input transfers, %0d assigned, %0d refused, %0d callbacks,",
             sb.transfers_in, sb.seen_kind[EV_ASSIGNED], sb.seen_kind[EV_NO_FREE],
             sb.seen_kind[EV_CALLBACK]);
    $display("summary: %0d pin toggles, %0d mismatches, %0d cycles",
             sb.seen_kind[EV_TOGGLE], sb.errors, cycle_count);
    if (sb.errors == 0)
      $display("multi_channel_event_timer_unit_test: done, clean");
    else
      $display("multi_channel_event_timer_unit_test: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

@@ multi_channel_event_timer_unit.f @@
src/metu_pkg.sv
src/metu_table.sv
src/multi_channel_event_timer_unit.sv
test/multi_channel_event_timer_unit_test.sv
